// File: design/pmst_pkg.sv
// Shared types and constants of the minimum spanning tree core.
package pmst_pkg;

	localparam int VERTEX_BITS    = 6;
	localparam int WEIGHT_IN_BITS = 16;
	localparam int NV_BITS        = 7;
	localparam logic [NV_BITS-1:0] NV_RESET = 7'd64;

	// Sequencer states of the core
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LD_CMP,
		ST_LD_WR2,
		ST_RELAX,
		ST_SCAN,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

endpackage

// File: design/pmst_if.sv
// Valid/ready channels for edge items and result items.
interface pmst_edge_if;
	logic                                  valid;
	logic                                  ready;
	logic [pmst_pkg::VERTEX_BITS-1:0]      edge_end_a;
	logic [pmst_pkg::VERTEX_BITS-1:0]      edge_end_b;
	logic [pmst_pkg::WEIGHT_IN_BITS-1:0]   edge_weight;
	logic                                  last_edge;

	modport source (output valid, edge_end_a, edge_end_b, edge_weight, last_edge, input ready);
	modport sink (input valid, edge_end_a, edge_end_b, edge_weight, last_edge, output ready);
endinterface

interface pmst_result_if;
	logic                                  valid;
	logic                                  ready;
	logic [pmst_pkg::VERTEX_BITS-1:0]      vertex;
	logic [pmst_pkg::VERTEX_BITS-1:0]      parent_vertex;
	logic                                  reachable;
	logic                                  last_result;

	modport source (output valid, vertex, parent_vertex, reachable, last_result, input ready);
	modport sink (input valid, vertex, parent_vertex, reachable, last_result, output ready);
endinterface

// File: design/pmst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pmst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read; hold data when not reading
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/prim_minimum_spanning_tree_core.sv
// Top level: edge loading into a weight matrix RAM and Prim tree growth over a vertex RAM.
//
//  channel    dir  handshake        payload
//  edges      in   valid/ready      edge_end_a, edge_end_b, edge_weight, last_edge
//  results    out  valid/ready      vertex, parent_vertex, reachable, last_result
//  cfg        in   cfg_we           cfg_wdata = num_vertices
//
// An edge item is read, compared and, when it lowers a stored weight, written twice
// (symmetric writes through the single matrix write port); edges wait until it is done.
// Each tree round makes one pass over the vertex RAM to relax and one to search the
// minimum key; then each result is read and loaded as the output register frees.
// After reset and after every run a clearing pass writes "no edge" to every matrix
// entry (MAX_VERTICES*MAX_VERTICES, 4096 at the defaults); edges are held off.
// A stalled results channel holds the emit sequence; the output register frees edges.
module prim_minimum_spanning_tree_core #(
	parameter int MAX_VERTICES = 64,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pmst_pkg::NV_BITS-1:0]  cfg_wdata,
	pmst_edge_if.sink                     edges,
	pmst_result_if.source                 results
);

	localparam int VW     = $clog2(MAX_VERTICES);
	localparam int NW     = VW + 1;
	localparam int KW     = WEIGHT_BITS + 1;
	localparam int MDEPTH = MAX_VERTICES * MAX_VERTICES;
	localparam int AW     = $clog2(MDEPTH);
	localparam int VWORD  = KW + 2 + VW;
	localparam int KEY_LO = VW + 2;
	localparam int TREE_B = VW + 1;
	localparam int HASP_B = VW;
	localparam logic [KW-1:0]    KEY_INF  = {1'b1, {WEIGHT_BITS{1'b0}}};
	localparam logic [VWORD-1:0] V_RESET  = {KEY_INF, 1'b0, 1'b0, {VW{1'b0}}};
	localparam logic [AW-1:0]    CLR_LAST = AW'(MDEPTH - 1);
	localparam logic [NW-1:0]    N_MAX    = NW'(MAX_VERTICES);

	pmst_pkg::state_t state_q, state_d;

	logic [pmst_pkg::NV_BITS-1:0] n_cfg_q;
	logic [NW-1:0]  n_cur, n_run_q, idx_q;
	logic [AW-1:0]  clr_q;
	logic [VW-1:0]  a_q, b_q, pick_q, s1_idx_q;
	logic [KW-1:0]  w_q, w_in, low_q;
	logic           last_q, inr_q, found_q;
	logic           s1_vld_q, s1_vbit_q;
	logic [MAX_VERTICES-1:0] vvalid_q;

	logic           in_acc, in_range, issue, scan_done, slot_free, emit_last, upd;
	logic [VW-1:0]  ain, bin, idx_v;

	logic           mat_we, mat_re;
	logic [AW-1:0]  mat_waddr, mat_raddr;
	logic [KW-1:0]  mat_wdata, mat_rdata;
	logic           vert_we, vert_re;
	logic [VW-1:0]  vert_waddr, vert_raddr;
	logic [VWORD-1:0] vert_wdata, vert_rdata, vrd;
	logic [KW-1:0]  vkey;
	logic           vtree, vhasp;
	logic [VW-1:0]  vpar;

	logic [pmst_pkg::VERTEX_BITS-1:0] out_vtx_q, out_par_q;
	logic           out_valid_q, out_reach_q, out_last_q;

	// Clamp the configured vertex count into 1..MAX_VERTICES
	always_comb begin
		if (n_cfg_q == '0) begin
			n_cur = NW'(1);
		end else if (32'(n_cfg_q) > 32'(MAX_VERTICES)) begin
			n_cur = N_MAX;
		end else begin
			n_cur = NW'(n_cfg_q);
		end
	end

	// Take the low weight bits into the key width
	always_comb begin
		w_in = '0;
		for (int k = 0; k < KW - 1 && k < pmst_pkg::WEIGHT_IN_BITS; k++) begin
			w_in[k] = edges.edge_weight[k];
		end
	end

	assign edges.ready = (state_q == pmst_pkg::ST_IDLE);
	assign in_acc      = edges.valid && edges.ready;
	assign ain         = VW'(edges.edge_end_a);
	assign bin         = VW'(edges.edge_end_b);
	assign in_range    = (32'(edges.edge_end_a) < 32'(n_cur)) &&
	                     (32'(edges.edge_end_b) < 32'(n_cur));
	assign idx_v       = idx_q[VW-1:0];
	assign issue       = ((state_q == pmst_pkg::ST_RELAX) || (state_q == pmst_pkg::ST_SCAN)) &&
	                     (idx_q < n_run_q);
	assign scan_done   = (idx_q == n_run_q) && !s1_vld_q;
	assign slot_free   = !out_valid_q || results.ready;
	assign emit_last   = ((idx_q + 1'b1) == n_run_q);
	assign upd         = inr_q && (w_q < mat_rdata);

	// Unwritten vertex entries read as their reset value
	assign vrd   = s1_vbit_q ? vert_rdata : V_RESET;
	assign vkey  = vrd[VWORD-1:KEY_LO];
	assign vtree = vrd[TREE_B];
	assign vhasp = vrd[HASP_B];
	assign vpar  = vrd[VW-1:0];

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pmst_pkg::ST_CLEAR: begin
				if (clr_q == CLR_LAST) state_d = pmst_pkg::ST_IDLE;
			end
			pmst_pkg::ST_IDLE: begin
				if (in_acc) state_d = pmst_pkg::ST_LD_CMP;
			end
			pmst_pkg::ST_LD_CMP: begin
				if (upd) state_d = pmst_pkg::ST_LD_WR2;
				else if (last_q) state_d = pmst_pkg::ST_RELAX;
				else state_d = pmst_pkg::ST_IDLE;
			end
			pmst_pkg::ST_LD_WR2: begin
				state_d = last_q ? pmst_pkg::ST_RELAX : pmst_pkg::ST_IDLE;
			end
			pmst_pkg::ST_RELAX: begin
				if (scan_done) state_d = pmst_pkg::ST_SCAN;
			end
			pmst_pkg::ST_SCAN: begin
				if (scan_done) begin
					if (found_q) state_d = pmst_pkg::ST_RELAX;
					else if (n_run_q > NW'(1)) state_d = pmst_pkg::ST_EMIT_RD;
					else state_d = pmst_pkg::ST_CLEAR;
				end
			end
			pmst_pkg::ST_EMIT_RD: begin
				state_d = pmst_pkg::ST_EMIT_LD;
			end
			pmst_pkg::ST_EMIT_LD: begin
				if (slot_free) state_d = emit_last ? pmst_pkg::ST_CLEAR : pmst_pkg::ST_EMIT_RD;
			end
			default: state_d = pmst_pkg::ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pmst_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_cfg_q <= pmst_pkg::NV_RESET;
		end else if (cfg_we) begin
			n_cfg_q <= cfg_wdata;
		end
	end

	// Capture the accepted edge
	always_ff @(posedge clk) begin
		if (in_acc) begin
			a_q     <= ain;
			b_q     <= bin;
			w_q     <= w_in;
			last_q  <= edges.last_edge;
			inr_q   <= in_range;
			n_run_q <= n_cur;
		end
	end

	// Matrix RAM port control: clearing pass, edge compare and symmetric writes, relax row
	always_comb begin
		mat_we    = 1'b0;
		mat_waddr = clr_q;
		mat_wdata = KEY_INF;
		mat_re    = 1'b0;
		mat_raddr = AW'(AW'(pick_q) * AW'(MAX_VERTICES) + AW'(idx_v));
		case (state_q)
			pmst_pkg::ST_CLEAR: begin
				mat_we = 1'b1;
			end
			pmst_pkg::ST_IDLE: begin
				mat_re    = in_acc;
				mat_raddr = AW'(AW'(ain) * AW'(MAX_VERTICES) + AW'(bin));
			end
			pmst_pkg::ST_LD_CMP: begin
				mat_we    = upd;
				mat_waddr = AW'(AW'(a_q) * AW'(MAX_VERTICES) + AW'(b_q));
				mat_wdata = w_q;
			end
			pmst_pkg::ST_LD_WR2: begin
				mat_we    = 1'b1;
				mat_waddr = AW'(AW'(b_q) * AW'(MAX_VERTICES) + AW'(a_q));
				mat_wdata = w_q;
			end
			pmst_pkg::ST_RELAX: begin
				mat_re = issue;
			end
			default: begin
				mat_re = 1'b0;
			end
		endcase
	end

	// Vertex RAM: read the swept entry, write back the relaxed key or the tree mark
	always_comb begin
		vert_re    = issue || (state_q == pmst_pkg::ST_EMIT_RD);
		vert_raddr = idx_v;
		vert_waddr = s1_idx_q;
		vert_we    = 1'b0;
		vert_wdata = vrd;
		if ((state_q == pmst_pkg::ST_RELAX) && s1_vld_q) begin
			if (s1_idx_q == pick_q) begin
				vert_we            = 1'b1;
				vert_wdata[TREE_B] = 1'b1;
			end else if (!vtree && (mat_rdata < vkey)) begin
				vert_we    = 1'b1;
				vert_wdata = {mat_rdata, 1'b0, 1'b1, pick_q};
			end
		end
	end

	// Sweep counters, search state and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			idx_q     <= '0;
			pick_q    <= '0;
			found_q   <= 1'b0;
			low_q     <= KEY_INF;
			s1_vld_q  <= 1'b0;
			s1_idx_q  <= '0;
			s1_vbit_q <= 1'b0;
			vvalid_q  <= '0;
		end else begin
			// advance the clearing pass
			if (state_q == pmst_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			else clr_q <= '0;

			// first stage of a sweep
			s1_vld_q <= issue;
			if (issue) begin
				idx_q     <= idx_q + 1'b1;
				s1_idx_q  <= idx_v;
				s1_vbit_q <= vvalid_q[idx_v];
			end
			if (state_q == pmst_pkg::ST_EMIT_RD) s1_vbit_q <= vvalid_q[idx_v];

			// minimum key search, lower index wins ties
			if ((state_q == pmst_pkg::ST_SCAN) && s1_vld_q && !vtree && (vkey < low_q)) begin
				low_q   <= vkey;
				pick_q  <= s1_idx_q;
				found_q <= 1'b1;
			end

			// round zero takes vertex 0
			if ((state_q == pmst_pkg::ST_LD_CMP || state_q == pmst_pkg::ST_LD_WR2) &&
			    state_d == pmst_pkg::ST_RELAX) begin
				pick_q <= '0;
			end

			if (state_d != state_q) begin
				if (state_d == pmst_pkg::ST_RELAX) idx_q <= '0;
				if (state_d == pmst_pkg::ST_SCAN) begin
					idx_q   <= '0;
					low_q   <= KEY_INF;
					found_q <= 1'b0;
				end
				if (state_q == pmst_pkg::ST_SCAN && state_d == pmst_pkg::ST_EMIT_RD) idx_q <= NW'(1);
			end
			if (state_q == pmst_pkg::ST_EMIT_LD && state_d == pmst_pkg::ST_EMIT_RD) begin
				idx_q <= idx_q + 1'b1;
			end

			// mark written entries; drop all marks when the run ends
			if (vert_we) vvalid_q[s1_idx_q] <= 1'b1;
			if (state_d == pmst_pkg::ST_CLEAR && state_q != pmst_pkg::ST_CLEAR) vvalid_q <= '0;
		end
	end

	// Result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == pmst_pkg::ST_EMIT_LD && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pmst_pkg::ST_EMIT_LD && slot_free) begin
			out_vtx_q   <= pmst_pkg::VERTEX_BITS'(idx_v);
			out_par_q   <= (vtree && vhasp) ? pmst_pkg::VERTEX_BITS'(vpar) : '0;
			out_reach_q <= vtree && vhasp;
			out_last_q  <= emit_last;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.vertex        = out_vtx_q;
	assign results.parent_vertex = out_par_q;
	assign results.reachable     = out_reach_q;
	assign results.last_result   = out_last_q;

	pmst_ram #(.WIDTH(KW), .DEPTH(MDEPTH)) u_mat_ram (
		.clk   (clk),
		.we    (mat_we),
		.waddr (mat_waddr),
		.wdata (mat_wdata),
		.re    (mat_re),
		.raddr (mat_raddr),
		.rdata (mat_rdata)
	);

	pmst_ram #(.WIDTH(VWORD), .DEPTH(MAX_VERTICES)) u_vert_ram (
		.clk   (clk),
		.we    (vert_we),
		.waddr (vert_waddr),
		.wdata (vert_wdata),
		.re    (vert_re),
		.raddr (vert_raddr),
		.rdata (vert_rdata)
	);

	// A new result only follows an emit load
	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(results.valid) |-> $past(state_q == pmst_pkg::ST_EMIT_LD))
		else $error("result raised outside emit");

	// Read and write of one vertex entry never coincide
	a_vert_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(vert_we && vert_re && (vert_waddr == vert_raddr)))
		else $error("vertex RAM read/write collision");

	// Clearing pass starts with no vertex entry marked
	a_clear_no_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pmst_pkg::ST_CLEAR) |-> (vvalid_q == '0))
		else $error("vertex marks left during clear");

	// Relax writes stay inside the active vertex range
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vert_we |-> (32'(s1_idx_q) < 32'(n_run_q)))
		else $error("vertex write beyond active range");

endmodule
